@@ rtl/sfpr_pkg.sv @@
package sfpr_pkg;

    // Byte width of the serial link
    localparam int BYTE_W = 8;

    // Frame length in bytes, both sync bytes included (4 .. 255)
    localparam int FRAME_LENGTH = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 1'd1;

    // Result payload packed into tdata: frame_byte low, byte_position high
    localparam int OUT_DATA_W = 2 * BYTE_W;

endpackage

@@ rtl/sync_framed_packet_receiver.sv @@
// Deframer for a byte stream that carries fixed-length frames opened by two
// sync bytes and closed by an additive checksum byte.
//
// Input channel (s_axis_*): one received byte per transfer.
// Output channel (m_axis_*): one transfer for every frame byte after the two
// sync bytes, with its position in the frame. tlast marks the checksum byte;
// tuser is set with tlast when the 8-bit wrapping sum of all earlier frame
// bytes, sync bytes included, equals that byte.
// Configuration: cfg_we / cfg_index / cfg_data write the first (index 0) and
// second (index 1) sync values. Write them while the stream is idle.
//
// Throughput: one byte per cycle while m_axis is not stalled. Each byte goes through a single add and
// compare between the phase/count/sum registers and the output register.
// A collected byte appears on m_axis in the cycle after its transfer.
// When the receiver stalls, the output register holds its transfer and
// s_axis_tready drops until the result is taken; a byte that yields no
// result still needs a free output slot to enter.
// Reset clears both sync values to zero, returns the hunt to the first sync
// byte, and empties the output register.
module sync_framed_packet_receiver
    import sfpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]     cfg_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] rx_byte

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] frame_byte, [15:8] byte_position
    output logic                  m_axis_tlast,   // frame_end
    output logic                  m_axis_tuser    // [0] checksum_good
);

    typedef enum logic [1:0] {
        PH_SYNC1 = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   count_reg, count_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic [BYTE_W-1:0]   first_sync_reg, first_sync_next;
    logic [BYTE_W-1:0]   second_sync_reg, second_sync_next;

    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [BYTE_W-1:0]   out_pos_reg, out_pos_next;
    logic                out_end_reg, out_end_next;
    logic                out_good_reg, out_good_next;

    logic                in_xfer;
    logic [BYTE_W:0]     count_inc;
    logic                last_byte;

    // Take a new byte whenever the output slot is free or is being emptied.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign count_inc = {1'b0, count_reg} + {{BYTE_W{1'b0}}, 1'b1};
    assign last_byte = count_inc >= (BYTE_W+1)'(FRAME_LENGTH);

    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        first_sync_next  = first_sync_reg;
        second_sync_next = second_sync_reg;

        // Drop the held result once it is taken.
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_pos_next   = out_pos_reg;
        out_end_next   = out_end_reg;
        out_good_next  = out_good_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_SYNC:  first_sync_next  = cfg_data;
                CFG_SECOND_SYNC: second_sync_next = cfg_data;
                default:         ;
            endcase
        end

        if (in_xfer)
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    // A mismatch is not retried as a first sync byte.
                    if (s_axis_tdata == second_sync_reg)
                    begin
                        sum_next   = sum_reg + s_axis_tdata;
                        count_next = BYTE_W'(2);
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_BODY:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = s_axis_tdata;
                    out_pos_next   = count_reg;
                    out_end_next   = last_byte;
                    out_good_next  = last_byte && (s_axis_tdata == sum_reg);
                    count_next     = count_inc[BYTE_W-1:0];
                    if (last_byte)
                    begin
                        phase_next = PH_SYNC1;
                    end
                    else
                    begin
                        sum_next = sum_reg + s_axis_tdata;
                    end
                end
                default:
                begin
                    // Hunt for the first sync byte; the spare phase code lands here too.
                    if (s_axis_tdata == first_sync_reg)
                    begin
                        sum_next   = s_axis_tdata;
                        count_next = BYTE_W'(1);
                        phase_next = PH_SYNC2;
                    end
                    else
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SYNC1;
            count_reg       <= '0;
            sum_reg         <= '0;
            first_sync_reg  <= '0;
            second_sync_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_byte_reg    <= '0;
            out_pos_reg     <= '0;
            out_end_reg     <= 1'b0;
            out_good_reg    <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            sum_reg         <= sum_next;
            first_sync_reg  <= first_sync_next;
            second_sync_reg <= second_sync_next;
            out_valid_reg   <= out_valid_next;
            out_byte_reg    <= out_byte_next;
            out_pos_reg     <= out_pos_next;
            out_end_reg     <= out_end_next;
            out_good_reg    <= out_good_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_pos_reg, out_byte_reg};
    assign m_axis_tlast  = out_end_reg;
    assign m_axis_tuser  = out_good_reg;

`ifndef SYNTHESIS
    // The end mark falls only on the last position of the frame.
    a_end_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (out_pos_reg == BYTE_W'(FRAME_LENGTH - 1)))
        else $error("frame end at wrong position");

    // Checksum flag is meaningful only with the end mark.
    a_good_with_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("checksum flag without frame end");

    // Sync bytes never reach the output.
    a_no_sync_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_pos_reg >= BYTE_W'(2)))
        else $error("sync byte position on output");

    // A body byte always yields a result in the next cycle.
    a_body_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (phase_reg == PH_BODY)) |=> m_axis_tvalid)
        else $error("body byte produced no result");

    // Collection never runs past the frame length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (count_reg < BYTE_W'(FRAME_LENGTH)))
        else $error("byte count beyond frame length");
`endif

endmodule
